[sv/abms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abms_pkg
// Shared constants, codes and interface structs of the burst memory slave.
// ----------------------------------------------------------------------------
package abms_pkg;

   // Memory geometry.
   localparam int unsigned WORD_BYTES = 8;
   localparam int unsigned LANE_W     = $clog2(WORD_BYTES);
   localparam logic [63:0] MEM_BYTES  = 64'd524288;
   localparam logic [63:0] WORD_COUNT = (MEM_BYTES + 64'(WORD_BYTES) - 64'd1) / 64'(WORD_BYTES);
   localparam int unsigned WORD_AW    = $clog2(WORD_COUNT);
   localparam int unsigned BANK_AW    = WORD_AW - 1;
   localparam int unsigned BANK_DEPTH = int'((WORD_COUNT + 64'd1) / 64'd2);
   // Highest offset at which a whole word still lies inside the memory.
   localparam logic [63:0] READ_LIMIT = MEM_BYTES - 64'(WORD_BYTES);

   // Request commands.
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WADDR = 2'd1;
   localparam logic [1:0] CMD_WDATA = 2'd2;

   // Response kinds.
   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_WRESP  = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   typedef struct packed {
      logic               en;
      logic [BANK_AW-1:0] even_idx;
      logic [BANK_AW-1:0] odd_idx;
   } mem_rd_type;

   typedef struct packed {
      logic               en;
      logic               odd;
      logic [BANK_AW-1:0] idx;
      logic [7:0]         be;
      logic [63:0]        data;
   } mem_wr_type;

   // Side information that travels with a beat from issue to the output.
   typedef struct packed {
      logic [1:0]        kind;
      logic [7:0]        id;
      logic              last;
      logic              err;
      logic              word_odd;
      logic [LANE_W-1:0] shift;
   } meta_type;

   // Byte lanes covered by a beat of 1 << size_log2 bytes.
   function automatic logic [7:0] size_lanes(input logic [1:0] size_log2);
      logic [7:0] lanes;
      case (size_log2)
         2'd0:    lanes = 8'h01;
         2'd1:    lanes = 8'h03;
         2'd2:    lanes = 8'h0F;
         default: lanes = 8'hFF;
      endcase
      return lanes;
   endfunction

endpackage
`default_nettype wire

[sv/abms_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abms_mem
// Word storage split into even and odd word banks, byte-enable writes and
// registered reads that hold their data while no read is issued.
// ----------------------------------------------------------------------------
module abms_mem import abms_pkg::*; (
   input  wire logic       clock,
   input  wire mem_rd_type mem_rd,
   input  wire mem_wr_type mem_wr,
   output logic [63:0]     even_data,
   output logic [63:0]     odd_data
);

   logic [63:0] bank_even [BANK_DEPTH];
   logic [63:0] bank_odd  [BANK_DEPTH];
   logic [63:0] even_data_ff;
   logic [63:0] odd_data_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < WORD_BYTES; i++) begin
         if (mem_wr.en && !mem_wr.odd && mem_wr.be[i]) begin
            bank_even[mem_wr.idx][8*i +: 8] <= mem_wr.data[8*i +: 8];
         end
      end
      if (mem_rd.en) begin
         even_data_ff <= bank_even[mem_rd.even_idx];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WORD_BYTES; i++) begin
         if (mem_wr.en && mem_wr.odd && mem_wr.be[i]) begin
            bank_odd[mem_wr.idx][8*i +: 8] <= mem_wr.data[8*i +: 8];
         end
      end
      if (mem_rd.en) begin
         odd_data_ff <= bank_odd[mem_rd.odd_idx];
      end
   end

   assign even_data = even_data_ff;
   assign odd_data  = odd_data_ff;

endmodule
`default_nettype wire

[sv/abms_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abms_ctrl
// Request decode, write burst state, read beat sequencer and the stage that
// holds a beat while its memory read completes.
// ----------------------------------------------------------------------------
module abms_ctrl import abms_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [63:0] base_address,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [63:0] req_addr,
   input  wire logic [7:0]  req_txn_id,
   input  wire logic [1:0]  req_size_log2,
   input  wire logic [5:0]  req_burst_len,
   input  wire logic [7:0]  req_byte_strobe,
   input  wire logic [63:0] req_write_data,
   input  wire logic        req_last_beat,
   output mem_rd_type       mem_rd,
   output mem_wr_type       mem_wr,
   output logic             m_valid,
   output meta_type         m_meta,
   input  wire logic        m_take
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type   state_ff, state_in;
   logic [63:0] rd_off_ff, rd_off_in;
   logic [5:0]  rd_left_ff, rd_left_in;
   logic [7:0]  rd_id_ff, rd_id_in;
   logic [63:0] wr_ptr_ff, wr_ptr_in;
   logic [7:0]  wr_id_ff, wr_id_in;
   logic [5:0]  wr_left_ff, wr_left_in;
   logic [1:0]  wr_size_ff, wr_size_in;
   logic        wr_open_ff, wr_open_in;
   logic        wr_failed_ff, wr_failed_in;
   logic        m_valid_ff, m_valid_in;
   meta_type    m_meta_ff, m_meta_in;

   logic        m_free;
   logic        accept;
   logic        push;
   logic [63:0] wr_off;
   logic        wr_inrange;
   logic [15:0] wr_mask_wide;
   logic [3:0]  beat_bytes;
   logic        wr_is_last;
   logic        wr_fail_now;
   logic [WORD_AW-1:0] rd_word;
   logic [WORD_AW:0]   rd_word_next;
   logic [WORD_AW-1:0] wr_word;

   assign m_free    = !m_valid_ff || m_take;
   assign req_stall = !((state_ff == ST_IDLE) && m_free);
   assign accept    = req_valid && !req_stall;

   // Write beat address decode, done against the live base register.
   assign wr_off       = wr_ptr_ff - base_address;
   assign wr_inrange   = wr_off < MEM_BYTES;
   assign wr_word      = wr_off[WORD_AW+LANE_W-1:LANE_W];
   assign wr_mask_wide = {8'd0, size_lanes(wr_size_ff)} << wr_off[LANE_W-1:0];
   assign beat_bytes   = 4'd1 << wr_size_ff;
   assign wr_is_last   = (wr_left_ff == 6'd0);
   assign wr_fail_now  = wr_failed_ff || !wr_inrange || (wr_is_last != req_last_beat);

   // A read beat may straddle two words: the even bank serves word w or w+1.
   assign rd_word      = rd_off_ff[WORD_AW+LANE_W-1:LANE_W];
   assign rd_word_next = {1'b0, rd_word} + {{WORD_AW{1'b0}}, 1'b1};

   always_comb begin
      state_in     = state_ff;
      rd_off_in    = rd_off_ff;
      rd_left_in   = rd_left_ff;
      rd_id_in     = rd_id_ff;
      wr_ptr_in    = wr_ptr_ff;
      wr_id_in     = wr_id_ff;
      wr_left_in   = wr_left_ff;
      wr_size_in   = wr_size_ff;
      wr_open_in   = wr_open_ff;
      wr_failed_in = wr_failed_ff;
      push         = 1'b0;
      m_meta_in    = m_meta_ff;

      mem_rd.en       = 1'b0;
      mem_rd.even_idx = rd_word_next[BANK_AW:1];
      mem_rd.odd_idx  = rd_word[WORD_AW-1:1];

      mem_wr.en   = 1'b0;
      mem_wr.odd  = wr_word[0];
      mem_wr.idx  = wr_word[WORD_AW-1:1];
      mem_wr.be   = req_byte_strobe & wr_mask_wide[7:0] & {8{wr_inrange}};
      mem_wr.data = req_write_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Default result is a rejection; accepted commands override it.
               m_meta_in.kind     = KIND_REJECT;
               m_meta_in.id       = req_txn_id;
               m_meta_in.last     = 1'b1;
               m_meta_in.err      = 1'b0;
               m_meta_in.word_odd = 1'b0;
               m_meta_in.shift    = '0;
               push               = 1'b1;
               if (req_cmd == CMD_READ) begin
                  push       = 1'b0;
                  rd_off_in  = {req_addr[63:LANE_W], {LANE_W{1'b0}}} - base_address;
                  rd_left_in = req_burst_len;
                  rd_id_in   = req_txn_id;
                  state_in   = ST_READ;
               end else if (req_cmd == CMD_WADDR && !wr_open_ff) begin
                  push         = 1'b0;
                  wr_ptr_in    = req_addr;
                  wr_id_in     = req_txn_id;
                  wr_left_in   = req_burst_len;
                  wr_size_in   = req_size_log2;
                  wr_open_in   = 1'b1;
                  wr_failed_in = 1'b0;
               end else if (req_cmd == CMD_WDATA && wr_open_ff) begin
                  mem_wr.en    = 1'b1;
                  wr_ptr_in    = wr_ptr_ff + {60'd0, beat_bytes};
                  wr_left_in   = wr_left_ff - 6'd1;
                  wr_failed_in = wr_fail_now;
                  push         = wr_is_last;
                  if (wr_is_last) begin
                     wr_open_in     = 1'b0;
                     m_meta_in.kind = KIND_WRESP;
                     m_meta_in.id   = wr_id_ff;
                     m_meta_in.err  = wr_fail_now;
                  end
               end
            end
         end
         ST_READ: begin
            if (m_free) begin
               mem_rd.en          = 1'b1;
               push               = 1'b1;
               m_meta_in.kind     = KIND_READ;
               m_meta_in.id       = rd_id_ff;
               m_meta_in.last     = (rd_left_ff == 6'd0);
               m_meta_in.err      = rd_off_ff > READ_LIMIT;
               m_meta_in.word_odd = rd_word[0];
               m_meta_in.shift    = rd_off_ff[LANE_W-1:0];
               rd_off_in          = rd_off_ff + 64'(WORD_BYTES);
               rd_left_in         = rd_left_ff - 6'd1;
               if (rd_left_ff == 6'd0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      m_valid_in = push ? 1'b1 : (m_take ? 1'b0 : m_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         wr_id_ff     <= '0;
         wr_left_ff   <= '0;
         wr_size_ff   <= '0;
         wr_open_ff   <= 1'b0;
         wr_failed_ff <= 1'b0;
         m_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         wr_id_ff     <= wr_id_in;
         wr_left_ff   <= wr_left_in;
         wr_size_ff   <= wr_size_in;
         wr_open_ff   <= wr_open_in;
         wr_failed_ff <= wr_failed_in;
         m_valid_ff   <= m_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_off_ff  <= rd_off_in;
      rd_left_ff <= rd_left_in;
      rd_id_ff   <= rd_id_in;
      m_meta_ff  <= m_meta_in;
   end

   assign m_valid = m_valid_ff;
   assign m_meta  = m_meta_ff;

endmodule
`default_nettype wire

[sv/abms_resp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abms_resp
// Aligns the two bank words to the beat offset and holds the response beat
// in the output register until it is taken.
// ----------------------------------------------------------------------------
module abms_resp import abms_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        m_valid,
   input  wire meta_type    m_meta,
   input  wire logic [63:0] even_data,
   input  wire logic [63:0] odd_data,
   output logic             m_take,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_resp_kind,
   output logic [7:0]       rsp_resp_id,
   output logic [63:0]      rsp_read_data,
   output logic             rsp_resp_last,
   output logic             rsp_error
);

   logic         out_valid_ff, out_valid_in;
   logic [1:0]   kind_ff;
   logic [7:0]   id_ff;
   logic [63:0]  data_ff, data_in;
   logic         last_ff;
   logic         err_ff;
   logic [63:0]  cur_word;
   logic [63:0]  next_word;
   logic [127:0] pair_shifted;
   logic         load;

   assign m_take = !out_valid_ff || !rsp_stall;
   assign load   = m_valid && m_take;

   assign cur_word     = m_meta.word_odd ? odd_data : even_data;
   assign next_word    = m_meta.word_odd ? even_data : odd_data;
   assign pair_shifted = {next_word, cur_word} >> {m_meta.shift, 3'b000};

   always_comb begin
      data_in = '0;
      if (m_meta.kind == KIND_READ && !m_meta.err) begin
         data_in = pair_shifted[63:0];
      end
      out_valid_in = load ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= m_meta.kind;
         id_ff   <= m_meta.id;
         data_ff <= data_in;
         last_ff <= m_meta.last;
         err_ff  <= m_meta.err;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_resp_kind = kind_ff;
   assign rsp_resp_id   = id_ff;
   assign rsp_read_data = data_ff;
   assign rsp_resp_last = last_ff;
   assign rsp_error     = err_ff;

endmodule
`default_nettype wire

[sv/axi_burst_memory_slave_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// axi_burst_memory_slave_top
// Word-wide burst memory slave with a base address register.
// ----------------------------------------------------------------------------
// A read request gives burst_len+1 beats, one beat per cycle while the hold
// stage is free, out of the read ports of the two word banks, before the next
// request is taken; its first beat passes the state register, the bank read
// registers and the output register. Every result passes one hold stage and
// an output register, so requests keep flowing while a response waits to be
// taken, until both hold a result. Memory contents come up undefined and need
// no clearing pass after reset; the base address register takes a write in
// any cycle and should only change between transactions.
module axi_burst_memory_slave_top import abms_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [63:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [63:0] req_addr,
   input  wire logic [7:0]  req_txn_id,
   input  wire logic [1:0]  req_size_log2,
   input  wire logic [5:0]  req_burst_len,
   input  wire logic [7:0]  req_byte_strobe,
   input  wire logic [63:0] req_write_data,
   input  wire logic        req_last_beat,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_resp_kind,
   output logic [7:0]       rsp_resp_id,
   output logic [63:0]      rsp_read_data,
   output logic             rsp_resp_last,
   output logic             rsp_error
);

   logic [63:0] base_address_ff;
   mem_rd_type  mem_rd;
   mem_wr_type  mem_wr;
   logic [63:0] even_data;
   logic [63:0] odd_data;
   logic        m_valid;
   meta_type    m_meta;
   logic        m_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= 64'h0000_0000_8000_0000;
      end else if (csr_valid && csr_ready) begin
         base_address_ff <= csr_write_data;
      end
   end

   abms_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .base_address    (base_address_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_addr        (req_addr),
      .req_txn_id      (req_txn_id),
      .req_size_log2   (req_size_log2),
      .req_burst_len   (req_burst_len),
      .req_byte_strobe (req_byte_strobe),
      .req_write_data  (req_write_data),
      .req_last_beat   (req_last_beat),
      .mem_rd          (mem_rd),
      .mem_wr          (mem_wr),
      .m_valid         (m_valid),
      .m_meta          (m_meta),
      .m_take          (m_take)
   );

   abms_mem u_mem (
      .clock     (clock),
      .mem_rd    (mem_rd),
      .mem_wr    (mem_wr),
      .even_data (even_data),
      .odd_data  (odd_data)
   );

   abms_resp u_resp (
      .clock         (clock),
      .reset         (reset),
      .m_valid       (m_valid),
      .m_meta        (m_meta),
      .even_data     (even_data),
      .odd_data      (odd_data),
      .m_take        (m_take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_resp_kind (rsp_resp_kind),
      .rsp_resp_id   (rsp_resp_id),
      .rsp_read_data (rsp_read_data),
      .rsp_resp_last (rsp_resp_last),
      .rsp_error     (rsp_error)
   );

   // A rejected item is answered with a single clean beat.
   a_reject_beat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_resp_kind == KIND_REJECT
         |-> rsp_resp_last && !rsp_error && rsp_read_data == 64'd0)
      else $error("rejection beat carries data, error or no last flag");

   // Out-of-range reads and failed writes never return memory contents.
   a_error_no_data : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_read_data == 64'd0)
      else $error("error beat carries nonzero data");

   // Write responses and rejections are always single-beat results.
   a_single_beat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_resp_kind != KIND_READ |-> rsp_resp_last)
      else $error("non-read result without last flag");

endmodule
`default_nettype wire

[tb/axi_burst_memory_slave_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axi_burst_memory_slave_top_tb
// Self-checking bench for the burst memory slave: a byte-accurate shadow of
// the memory window predicts every read beat, write response and rejection,
// and the results are compared in order under random idling and stalls.
// ----------------------------------------------------------------------------
module axi_burst_memory_slave_top_tb import abms_pkg::*; ();

   localparam logic [1:0] CMD_UNDEF    = 2'd3;
   localparam int         WORDS        = int'(WORD_COUNT);
   localparam int         REGION_WORDS = 64;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] addr;
      logic [7:0]  id;
      logic [1:0]  size;
      logic [5:0]  len;
      logic [7:0]  strb;
      logic [63:0] data;
      logic        last;
   } mem_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  id;
      logic [63:0] data;
      logic        last;
      logic        err;
   } mem_rsp_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_ALTERNATE} stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [63:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_READ;
   logic [63:0] req_addr = '0;
   logic [7:0]  req_txn_id = '0;
   logic [1:0]  req_size_log2 = '0;
   logic [5:0]  req_burst_len = '0;
   logic [7:0]  req_byte_strobe = '0;
   logic [63:0] req_write_data = '0;
   logic        req_last_beat = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_resp_kind;
   logic [7:0]  rsp_resp_id;
   logic [63:0] rsp_read_data;
   logic        rsp_resp_last;
   logic        rsp_error;

   axi_burst_memory_slave_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_addr        (req_addr),
      .req_txn_id      (req_txn_id),
      .req_size_log2   (req_size_log2),
      .req_burst_len   (req_burst_len),
      .req_byte_strobe (req_byte_strobe),
      .req_write_data  (req_write_data),
      .req_last_beat   (req_last_beat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_resp_kind   (rsp_resp_kind),
      .rsp_resp_id     (rsp_resp_id),
      .rsp_read_data   (rsp_read_data),
      .rsp_resp_last   (rsp_resp_last),
      .rsp_error       (rsp_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the block: memory by offset from the base, plus which bytes
   // hold known data so that no read ever touches an unwritten byte.
   bit   [63:0] mem_image [WORDS];
   bit   [7:0]  mem_known [WORDS];
   logic [63:0] base_addr = 64'h8000_0000;
   logic [63:0] wr_ptr    = '0;
   logic [7:0]  wr_id     = '0;
   int          wr_left   = 0;
   int          wr_bytes  = 0;
   bit          wr_open   = 1'b0;
   bit          wr_fail   = 1'b0;

   mem_rsp_type awaited_rsp [$];

   int n_items = 0, n_checked = 0, n_errors = 0;
   int n_read_beats = 0, n_wresp = 0, n_rejects = 0, n_err_flags = 0, n_bases = 0;
   int send_run = 0;

   function automatic mem_rsp_type make_rsp(input logic [1:0] kind, input logic [7:0] id,
                                            input logic [63:0] data, input logic last,
                                            input logic err);
      mem_rsp_type r;
      r.kind = kind;
      r.id   = id;
      r.data = data;
      r.last = last;
      r.err  = err;
      return r;
   endfunction

   function automatic bit read_beat_in_range(input logic [63:0] off);
      return off < MEM_BYTES && (MEM_BYTES - off) >= 64'(WORD_BYTES);
   endfunction

   // True when every in-range beat of the read touches only known bytes.
   function automatic bit read_is_defined(input logic [63:0] addr, input logic [5:0] len);
      logic [63:0] off, p;
      for (int i = 0; i <= len; i++) begin
         off = {addr[63:3], 3'b000} + 64'(i) * 64'd8 - base_addr;
         if (read_beat_in_range(off)) begin
            for (int b = 0; b < 8; b++) begin
               p = off + 64'(b);
               if (!mem_known[p[WORD_AW+2:3]][p[2:0]])
                  return 1'b0;
            end
         end
      end
      return 1'b1;
   endfunction

   // Updates the shadow for one accepted request and queues its results.
   task automatic apply_request(input mem_req_type r);
      logic [63:0] off, p, word, lane_mask;
      logic [7:0]  en;
      bit          bad;
      if (r.cmd == CMD_READ) begin
         for (int i = 0; i <= r.len; i++) begin
            off  = {r.addr[63:3], 3'b000} + 64'(i) * 64'd8 - base_addr;
            bad  = !read_beat_in_range(off);
            word = '0;
            if (!bad) begin
               for (int b = 0; b < 8; b++) begin
                  p = off + 64'(b);
                  word[8*b +: 8] = mem_image[p[WORD_AW+2:3]][8*p[2:0] +: 8];
               end
            end
            awaited_rsp.push_back(make_rsp(KIND_READ, r.id, word, i == r.len, bad));
         end
      end else if (r.cmd == CMD_WADDR && !wr_open) begin
         wr_ptr   = r.addr;
         wr_id    = r.id;
         wr_left  = int'(r.len) + 1;
         wr_bytes = 1 << r.size;
         wr_open  = 1'b1;
         wr_fail  = 1'b0;
      end else if (r.cmd == CMD_WDATA && wr_open) begin
         off = wr_ptr - base_addr;
         if (off < MEM_BYTES) begin
            lane_mask = ((64'd1 << wr_bytes) - 64'd1) << off[2:0];
            en = r.strb & lane_mask[7:0];
            for (int b = 0; b < 8; b++) begin
               if (en[b]) begin
                  mem_image[off[WORD_AW+2:3]][8*b +: 8] = r.data[8*b +: 8];
                  mem_known[off[WORD_AW+2:3]][b] = 1'b1;
               end
            end
         end else begin
            wr_fail = 1'b1;
         end
         wr_ptr  = wr_ptr + 64'(wr_bytes);
         wr_left = wr_left - 1;
         if (wr_left == 0) begin
            if (!r.last)
               wr_fail = 1'b1;
            wr_open = 1'b0;
            awaited_rsp.push_back(make_rsp(KIND_WRESP, wr_id, '0, 1'b1, wr_fail));
         end else if (r.last) begin
            wr_fail = 1'b1;
         end
      end else begin
         awaited_rsp.push_back(make_rsp(KIND_REJECT, r.id, '0, 1'b1, 1'b0));
      end
   endtask

   // Sender: runs of back-to-back beats separated by random gaps.
   task automatic send_req(input mem_req_type r);
      int gap;
      @(negedge clock);
      if (send_run == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         send_run = $urandom_range(1, 24);
      end
      send_run--;
      req_cmd         = r.cmd;
      req_addr        = r.addr;
      req_txn_id      = r.id;
      req_size_log2   = r.size;
      req_burst_len   = r.len;
      req_byte_strobe = r.strb;
      req_write_data  = r.data;
      req_last_beat   = r.last;
      req_valid       = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_items++;
      apply_request(r);
   endtask

   function automatic mem_req_type scrambled_req();
      mem_req_type r;
      r.cmd  = 2'($urandom_range(0, 3));
      r.addr = {$urandom, $urandom};
      r.id   = 8'($urandom);
      r.size = 2'($urandom);
      r.len  = 6'($urandom);
      r.strb = 8'($urandom);
      r.data = {$urandom, $urandom};
      r.last = 1'($urandom);
      return r;
   endfunction

   task automatic send_read(input logic [63:0] addr, input logic [5:0] len);
      mem_req_type r;
      r = scrambled_req();
      r.cmd  = CMD_READ;
      r.addr = addr;
      r.len  = len;
      send_req(r);
   endtask

   // Always a rejected item: an undefined command or one that is out of turn.
   task automatic send_noise();
      mem_req_type r;
      r = scrambled_req();
      r.cmd = ($urandom_range(0, 1) == 0) ? CMD_UNDEF : (wr_open ? CMD_WADDR : CMD_WDATA);
      send_req(r);
   endtask

   task automatic random_read();
      logic [63:0] a;
      logic [5:0]  n;
      int          pick;
      for (int t = 0; t < 8; t++) begin
         pick = $urandom_range(0, 99);
         n = (pick % 5 == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
         if (pick < 70)
            a = base_addr + 64'($urandom_range(0, REGION_WORDS * 8 - 1));
         else if (pick < 85)
            a = base_addr + MEM_BYTES - 64'($urandom_range(1, 64));
         else
            a = {$urandom, $urandom};
         if (read_is_defined(a, n)) begin
            send_read(a, n);
            return;
         end
      end
      // Just below the window every beat is out of range.
      send_read(base_addr - 64'd64, 6'($urandom_range(0, 7)));
   endtask

   // One write burst; fault_beat flips the last flag on that beat (-1: none).
   task automatic send_write(input logic [63:0] addr, input logic [1:0] size,
                             input logic [5:0] len, input int fault_beat,
                             input bit full_strobe, input bit interleave);
      mem_req_type r;
      r = scrambled_req();
      r.cmd  = CMD_WADDR;
      r.addr = addr;
      r.size = size;
      r.len  = len;
      send_req(r);
      for (int i = 0; i <= len; i++) begin
         if (interleave && $urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 0)
               random_read();
            else
               send_noise();
         end
         r = scrambled_req();
         r.cmd = CMD_WDATA;
         if (full_strobe)
            r.strb = 8'hFF;
         r.last = (i == len) ^ (i == fault_beat);
         send_req(r);
      end
   endtask

   task automatic random_write();
      logic [63:0] a;
      logic [5:0]  n;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 75)
         a = base_addr + 64'($urandom_range(0, (REGION_WORDS + 32) * 8 - 1));
      else if (pick < 85)
         a = base_addr + MEM_BYTES - 64'($urandom_range(1, 64));
      else
         a = {$urandom, $urandom};
      n = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
      send_write(a, 2'($urandom_range(0, 3)), n,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : -1,
                 $urandom_range(0, 9) < 3, 1'b1);
   endtask

   // Waits until every predicted beat has arrived, then lets the pipe drain.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_base(input logic [63:0] value);
      settle();
      @(negedge clock);
      csr_write_data = value;
      csr_valid      = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      base_addr = value;
      n_bases++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic run_mixed_traffic(input int count);
      int stop, pick;
      stop = n_items + count;
      while (n_items < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)
            random_read();
         else if (pick < 85)
            random_write();
         else
            send_noise();
      end
      settle();
   endtask

   // Known data in the low window and in the top eight words, at reset base.
   task automatic test_preload_window();
      send_write(base_addr, 2'd3, 6'd63, -1, 1'b1, 1'b0);
      send_write(base_addr + MEM_BYTES - 64'd64, 2'd3, 6'd7, -1, 1'b1, 1'b0);
      settle();
   endtask

   task automatic test_read_edges();
      send_read(base_addr - 64'd8, 6'd1);
      send_read(base_addr + MEM_BYTES - 64'd16, 6'd3);
      send_read(base_addr + 64'd5, 6'd63);
      send_read(64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
      settle();
   endtask

   task automatic test_write_edges();
      send_write(base_addr + 64'd5, 2'd0, 6'd3, -1, 1'b1, 1'b0);
      send_write(base_addr + 64'h21, 2'd1, 6'd0, -1, 1'b0, 1'b0);
      send_write(base_addr + 64'h44, 2'd2, 6'd0, -1, 1'b0, 1'b0);
      // The second beat lands past the end of the window.
      send_write(base_addr + MEM_BYTES - 64'd8, 2'd3, 6'd1, -1, 1'b1, 1'b0);
      send_write(base_addr + 64'h100, 2'd3, 6'd1, 0, 1'b1, 1'b0);
      send_write(base_addr + 64'h140, 2'd3, 6'd0, 0, 1'b1, 1'b0);
      settle();
   endtask

   task automatic test_rejects();
      mem_req_type r;
      r = scrambled_req();
      r.cmd = CMD_UNDEF;
      send_req(r);
      r = scrambled_req();
      r.cmd = CMD_WDATA;
      send_req(r);
      r = scrambled_req();
      r.cmd  = CMD_WADDR;
      r.addr = base_addr + 64'h200;
      r.size = 2'd3;
      r.len  = 6'd0;
      send_req(r);
      r = scrambled_req();
      r.cmd = CMD_WADDR;
      send_req(r);
      r = scrambled_req();
      r.cmd  = CMD_WDATA;
      r.last = 1'b1;
      send_req(r);
      settle();
   endtask

   task automatic test_base_sweep();
      logic [63:0] bases [4];
      bases[0] = 64'h0;
      bases[1] = 64'hFFFF_FFFF_FFFF_FFFF;
      bases[2] = {$urandom, $urandom};
      bases[3] = 64'h8000_0000;
      run_mixed_traffic(25);
      for (int k = 0; k < 4; k++) begin
         set_base(bases[k]);
         run_mixed_traffic(25);
      end
   endtask

   // Receiver: stall pattern switches at random between the modes.
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= !rsp_stall;
      endcase
   end

   task automatic report_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         n_errors++;
      end
   endtask

   mem_rsp_type rsp_want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got kind %0d id %h data %h",
                     $time, rsp_resp_kind, rsp_resp_id, rsp_read_data);
            n_errors++;
         end else begin
            rsp_want = awaited_rsp.pop_front();
            n_checked++;
            report_field("resp_kind", 64'(rsp_want.kind), 64'(rsp_resp_kind));
            report_field("resp_id", 64'(rsp_want.id), 64'(rsp_resp_id));
            report_field("read_data", rsp_want.data, rsp_read_data);
            report_field("resp_last", 64'(rsp_want.last), 64'(rsp_resp_last));
            report_field("error", 64'(rsp_want.err), 64'(rsp_error));
            case (rsp_want.kind)
               KIND_READ:  n_read_beats++;
               KIND_WRESP: n_wresp++;
               default:    n_rejects++;
            endcase
            if (rsp_want.err)
               n_err_flags++;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_preload_window();
      test_read_edges();
      test_write_edges();
      test_rejects();
      test_base_sweep();
      settle();
      $display("Sent %0d requests and checked %0d beats: %0d read, %0d write response,",
               n_items, n_checked, n_read_beats, n_wresp);
      $display("%0d rejected; base register took %0d values, %0d beats flagged an error.",
               n_rejects, n_bases, n_err_flags);
      if (n_errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d beats still awaited.", awaited_rsp.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
